/* sv/tahc_pkg.sv */
// package: shared types and constants of the tilt alarm hysteresis controller
package tahc_pkg;

  localparam int RollW   = 13;
  localparam int MagW    = 13;
  localparam int TimeW   = 32;
  localparam int ThrW    = 12;
  localparam int PwmW    = 10;
  localparam int CfgIdxW = 3;

  // tilt levels
  typedef enum logic [1:0] {
    LVL_STABLE   = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_DANGER   = 2'd2,
    LVL_ROLLOVER = 2'd3
  } level_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WARN_ENTER     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WARN_EXIT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DANGER_ENTER   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DANGER_EXIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROLLOVER_ENTER = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ROLLOVER_EXIT  = 3'd5;

  // threshold reset values, 1/16 degree
  localparam logic [ThrW-1:0] WarnEnterRst     = 12'd272;
  localparam logic [ThrW-1:0] WarnExitRst      = 12'd208;
  localparam logic [ThrW-1:0] DangerEnterRst   = 12'd512;
  localparam logic [ThrW-1:0] DangerExitRst    = 12'd448;
  localparam logic [ThrW-1:0] RolloverEnterRst = 12'd752;
  localparam logic [ThrW-1:0] RolloverExitRst  = 12'd688;

  // blink periods, ms
  localparam logic [TimeW-1:0] WarnBlinkMs   = 32'd700;
  localparam logic [TimeW-1:0] DangerBlinkMs = 32'd333;
  localparam logic [TimeW-1:0] RollBlinkMs   = 32'd200;

  // motor pwm compare values
  localparam logic [PwmW-1:0] PwmStable   = 10'd999;
  localparam logic [PwmW-1:0] PwmWarning  = 10'd699;
  localparam logic [PwmW-1:0] PwmDanger   = 10'd399;
  localparam logic [PwmW-1:0] PwmRollover = 10'd0;

endpackage

/* sv/tahc_in_if.sv */
// interface: roll sample request channel
interface tahc_in_if;
  import tahc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RollW-1:0] roll;
  logic [TimeW-1:0]        now_ms;

  modport source (output valid, output roll, output now_ms, input ready);
  modport sink   (input valid, input roll, input now_ms, output ready);
endinterface

/* sv/tahc_out_if.sv */
// interface: lamp, buzzer and pwm result channel
interface tahc_out_if;
  import tahc_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      tilt_level;
  logic            green_lamp;
  logic            yellow_lamp;
  logic            red_lamp;
  logic            buzzer_on;
  logic [PwmW-1:0] pwm_compare;

  modport source (output valid, output tilt_level, output green_lamp, output yellow_lamp,
                  output red_lamp, output buzzer_on, output pwm_compare, input ready);
  modport sink   (input valid, input tilt_level, input green_lamp, input yellow_lamp,
                  input red_lamp, input buzzer_on, input pwm_compare, output ready);
endinterface

/* sv/tahc_cfg_if.sv */
// interface: threshold register write channel
interface tahc_cfg_if;
  import tahc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ThrW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tilt_alarm_hysteresis_controller_core.sv */
// top level: tilt alarm with hysteresis, lamp, buzzer and pwm drive
//
// channels
//   sample : roll request (13-bit signed, 1/16 degree) with a ms timestamp
//   result : one result per sample: tilt level, three lamps, buzzer, pwm
//   cfg    : threshold register writes, always ready, index 6 and 7 ignored
// every port moves a request on a clock edge with valid and ready high
//
// datapath and throughput
//   a sample is held in an input register, then compare and blink logic
//   loads the result register from it.
//   one sample is taken every cycle while results are drained
// stalls
//   while result is stalled, the input register still takes one more
//   sample; further samples wait until the result register frees up
// reset (rst, synchronous, active high)
//   level back to stable, blink timestamp and buzzer/red state cleared,
//   thresholds back to their default values, both registers empty
module tilt_alarm_hysteresis_controller_core (
  input  logic       clk,
  input  logic       rst,
  tahc_in_if.sink    sample,
  tahc_out_if.source result,
  tahc_cfg_if.sink   cfg
);
  import tahc_pkg::*;

  // threshold registers
  logic [ThrW-1:0] warn_enter, warn_exit;
  logic [ThrW-1:0] danger_enter, danger_exit;
  logic [ThrW-1:0] rollover_enter, rollover_exit;

  // input register
  logic                    in_valid;
  logic signed [RollW-1:0] in_roll;
  logic [TimeW-1:0]        in_now;

  // carried state
  level_t           level, level_next;
  logic [TimeW-1:0] last_toggle, last_toggle_next;
  logic             buzzer, buzzer_next;
  logic             red, red_next;

  // result register
  logic            out_valid;
  logic [1:0]      out_level;
  logic            out_green, out_yellow;
  logic [PwmW-1:0] out_pwm;

  logic             advance;
  logic [MagW-1:0]  mag;
  logic [TimeW-1:0] elapsed;
  logic             green_next, yellow_next;
  logic [PwmW-1:0]  pwm_next;

  // the staged sample moves on when the result register is free or drained
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_enter     <= WarnEnterRst;
      warn_exit      <= WarnExitRst;
      danger_enter   <= DangerEnterRst;
      danger_exit    <= DangerExitRst;
      rollover_enter <= RolloverEnterRst;
      rollover_exit  <= RolloverExitRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WARN_ENTER:     warn_enter     <= cfg.data;
        CFG_WARN_EXIT:      warn_exit      <= cfg.data;
        CFG_DANGER_ENTER:   danger_enter   <= cfg.data;
        CFG_DANGER_EXIT:    danger_exit    <= cfg.data;
        CFG_ROLLOVER_ENTER: rollover_enter <= cfg.data;
        CFG_ROLLOVER_EXIT:  rollover_exit  <= cfg.data;
        default: ;  // unused indexes
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_roll <= sample.roll;
      in_now  <= sample.now_ms;
    end
  end

  // absolute roll; the most negative code gives 4096, which still fits unsigned
  assign mag = in_roll[RollW-1] ? MagW'(-in_roll) : MagW'(in_roll);

  // level moves at most one step, with enter/exit hysteresis
  always_comb begin
    level_next = level;
    unique case (level)
      LVL_STABLE: begin
        if (mag > MagW'(warn_enter)) level_next = LVL_WARNING;
      end
      LVL_WARNING: begin
        if (mag < MagW'(warn_exit))         level_next = LVL_STABLE;
        else if (mag > MagW'(danger_enter)) level_next = LVL_DANGER;
      end
      LVL_DANGER: begin
        if (mag < MagW'(danger_exit))         level_next = LVL_WARNING;
        else if (mag > MagW'(rollover_enter)) level_next = LVL_ROLLOVER;
      end
      LVL_ROLLOVER: begin
        if (mag < MagW'(rollover_exit)) level_next = LVL_DANGER;
      end
    endcase
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = in_now - last_toggle;

  // lamps, buzzer and blink timing from the new level
  always_comb begin
    green_next       = 1'b0;
    yellow_next      = 1'b0;
    buzzer_next      = buzzer;
    red_next         = red;
    last_toggle_next = last_toggle;
    pwm_next         = PwmStable;
    unique case (level_next)
      LVL_STABLE: begin
        green_next  = 1'b1;
        red_next    = 1'b0;
        buzzer_next = 1'b0;
        pwm_next    = PwmStable;
      end
      LVL_WARNING: begin
        yellow_next = 1'b1;
        red_next    = 1'b0;
        pwm_next    = PwmWarning;
        if (elapsed >= WarnBlinkMs) begin
          buzzer_next      = !buzzer;
          last_toggle_next = in_now;
        end
      end
      LVL_DANGER: begin
        red_next = 1'b1;
        pwm_next = PwmDanger;
        if (elapsed >= DangerBlinkMs) begin
          buzzer_next      = !buzzer;
          last_toggle_next = in_now;
        end
      end
      LVL_ROLLOVER: begin
        buzzer_next = 1'b1;
        pwm_next    = PwmRollover;
        if (elapsed >= RollBlinkMs) begin
          red_next         = !red;
          last_toggle_next = in_now;
        end
      end
    endcase
  end

  // carried state updates once per staged sample
  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= LVL_STABLE;
      last_toggle <= '0;
      buzzer      <= 1'b0;
      red         <= 1'b0;
    end else if (advance) begin
      level       <= level_next;
      last_toggle <= last_toggle_next;
      buzzer      <= buzzer_next;
      red         <= red_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level  <= 2'(level_next);
      out_green  <= green_next;
      out_yellow <= yellow_next;
      out_pwm    <= pwm_next;
    end
  end

  // red and buzzer outputs are the carried state itself
  assign result.valid       = out_valid;
  assign result.tilt_level  = out_level;
  assign result.green_lamp  = out_green;
  assign result.yellow_lamp = out_yellow;
  assign result.red_lamp    = red;
  assign result.buzzer_on   = buzzer;
  assign result.pwm_compare = out_pwm;

endmodule

/* dv/testbench.sv */
// testbench: checks the tilt alarm core against a cycle-free model of its level, lamp and blink logic
module testbench;
  import tahc_pkg::*;

  // register indexes beyond the six thresholds, written to check they are ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT   = 2000; // cycles with no request moving on any channel
  localparam int SETTLE_CYCLES = 8;    // well beyond the latency
  localparam int ROLL_SPAN     = 2880; // legal roll range is +/- this
  localparam int HOLD_CYCLES   = 150;  // long receiver hold-off to fill the block

  // one expected result request
  typedef struct packed {
    level_t          level;
    logic            green;
    logic            yellow;
    logic            red;
    logic            buzzer;
    logic [PwmW-1:0] pwm;
  } lamp_drive_t;

  logic clk;
  logic rst;

  tahc_in_if  sample_ch ();
  tahc_out_if result_ch ();
  tahc_cfg_if cfg_ch ();

  tilt_alarm_hysteresis_controller_core DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // model copy of the threshold registers
  logic [ThrW-1:0] thr_warn_enter;
  logic [ThrW-1:0] thr_warn_exit;
  logic [ThrW-1:0] thr_danger_enter;
  logic [ThrW-1:0] thr_danger_exit;
  logic [ThrW-1:0] thr_roll_enter;
  logic [ThrW-1:0] thr_roll_exit;

  // model copy of the alarm state
  level_t           alarm_level;
  logic [TimeW-1:0] toggle_ms;
  logic             buzz_state;
  logic             red_state;

  // results still owed by the block, oldest first
  lamp_drive_t owed_drive_q[$];

  int error_count;

  // idling controls, shared by the test tasks and the receiver process
  bit tx_gaps;
  bit rx_gaps;
  int rx_hold_len;

  // random walk state for roll and timestamp
  int               walk_roll;
  logic [TimeW-1:0] walk_ms;

  int quiet_cycles;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of one sample: moves the level at most one step, then works out the
  // lamps, buzzer and pwm from the new level
  // ---------------------------------------------------------------------------
  function automatic lamp_drive_t advance_alarm(input logic signed [RollW-1:0] roll,
                                                input logic [TimeW-1:0] now);
    logic [MagW-1:0] mag;
    lamp_drive_t     drive;
    // absolute value; the most negative pattern gives 4096, which still fits
    mag = roll[RollW-1] ? MagW'(~roll + 1'b1) : MagW'(roll);

    // hysteresis: enter on strictly above, leave on strictly below
    unique case (alarm_level)
      LVL_STABLE: begin
        if (mag > thr_warn_enter) alarm_level = LVL_WARNING;
      end
      LVL_WARNING: begin
        if (mag < thr_warn_exit) alarm_level = LVL_STABLE;
        else if (mag > thr_danger_enter) alarm_level = LVL_DANGER;
      end
      LVL_DANGER: begin
        if (mag < thr_danger_exit) alarm_level = LVL_WARNING;
        else if (mag > thr_roll_enter) alarm_level = LVL_ROLLOVER;
      end
      default: begin
        if (mag < thr_roll_exit) alarm_level = LVL_DANGER;
      end
    endcase

    drive = '0;
    drive.level = alarm_level;
    // elapsed time is taken modulo 2^32, so a wrapped timestamp is a large gap
    unique case (alarm_level)
      LVL_STABLE: begin
        drive.green = 1'b1;
        red_state   = 1'b0;
        buzz_state  = 1'b0;
        drive.pwm   = PwmStable;
      end
      LVL_WARNING: begin
        if (TimeW'(now - toggle_ms) >= WarnBlinkMs) begin
          toggle_ms  = now;
          buzz_state = ~buzz_state;
        end
        drive.yellow = 1'b1;
        red_state    = 1'b0;
        drive.pwm    = PwmWarning;
      end
      LVL_DANGER: begin
        if (TimeW'(now - toggle_ms) >= DangerBlinkMs) begin
          toggle_ms  = now;
          buzz_state = ~buzz_state;
        end
        red_state = 1'b1;
        drive.pwm = PwmDanger;
      end
      default: begin
        // buzzer held on, red lamp blinks on the shared timestamp
        buzz_state = 1'b1;
        drive.pwm  = PwmRollover;
        if (TimeW'(now - toggle_ms) >= RollBlinkMs) begin
          toggle_ms = now;
          red_state = ~red_state;
        end
      end
    endcase
    drive.red    = red_state;
    drive.buzzer = buzz_state;
    return drive;
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks: all start and end at a falling edge
  // ---------------------------------------------------------------------------

  // one threshold write; the model copy follows the same index decode
  task automatic write_threshold(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    unique case (idx)
      CFG_WARN_ENTER:     thr_warn_enter   = val;
      CFG_WARN_EXIT:      thr_warn_exit    = val;
      CFG_DANGER_ENTER:   thr_danger_enter = val;
      CFG_DANGER_EXIT:    thr_danger_exit  = val;
      CFG_ROLLOVER_ENTER: thr_roll_enter   = val;
      CFG_ROLLOVER_EXIT:  thr_roll_exit    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // one sample request; the expected result is queued at the accepting edge
  task automatic send_sample(input logic signed [RollW-1:0] roll, input logic [TimeW-1:0] now);
    sample_ch.valid  = 1'b1;
    sample_ch.roll   = roll;
    sample_ch.now_ms = now;
    do @(posedge clk); while (!sample_ch.ready);
    owed_drive_q.push_back(advance_alarm(roll, now));
    @(negedge clk);
    sample_ch.valid = 1'b0;
    if (tx_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  // sender pause until the block has handed back every result
  task automatic wait_drain();
    while (owed_drive_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_all_thresholds(input logic [ThrW-1:0] val);
    write_threshold(CFG_WARN_ENTER, val);
    write_threshold(CFG_WARN_EXIT, val);
    write_threshold(CFG_DANGER_ENTER, val);
    write_threshold(CFG_DANGER_EXIT, val);
    write_threshold(CFG_ROLLOVER_ENTER, val);
    write_threshold(CFG_ROLLOVER_EXIT, val);
  endtask

  // thresholds in the usual order, each exit at or below its enter
  task automatic write_ordered_thresholds();
    int wx, we, dx, de, rx, re;
    wx = $urandom_range(0, 300);
    we = wx + $urandom_range(0, 100);
    dx = we + $urandom_range(0, 300);
    de = dx + $urandom_range(0, 100);
    rx = de + $urandom_range(0, 300);
    re = rx + $urandom_range(0, 100);
    write_threshold(CFG_WARN_ENTER, ThrW'(we));
    write_threshold(CFG_WARN_EXIT, ThrW'(wx));
    write_threshold(CFG_DANGER_ENTER, ThrW'(de));
    write_threshold(CFG_DANGER_EXIT, ThrW'(dx));
    write_threshold(CFG_ROLLOVER_ENTER, ThrW'(re));
    write_threshold(CFG_ROLLOVER_EXIT, ThrW'(rx));
  endtask

  // random walk of roll with mostly rising timestamps; a few requests are
  // raw bit patterns with a jumped timestamp
  task automatic drive_walk(input int count);
    logic signed [RollW-1:0] roll;
    int                      pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        roll    = RollW'($urandom);
        walk_ms = $urandom;
      end else begin
        if (pick == 1) walk_roll = int'($urandom_range(0, 2 * ROLL_SPAN)) - ROLL_SPAN;
        else walk_roll += int'($urandom_range(0, 300)) - 150;
        if (walk_roll > ROLL_SPAN) walk_roll = ROLL_SPAN;
        if (walk_roll < -ROLL_SPAN) walk_roll = -ROLL_SPAN;
        roll    = RollW'(walk_roll);
        walk_ms = walk_ms + $urandom_range(0, 400);
      end
      // occasional drain pause only while sender idling is allowed
      if (tx_gaps && $urandom_range(0, 149) == 0) wait_drain();
      send_sample(roll, walk_ms);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset thresholds: every level, boundary equality, blink boundaries, field
  // extremes and timestamp wrap
  task automatic test_directed();
    int               dir_roll [18] = '{0, 273, 273, 272, -513, 512, -2880, 2880, 752, 687,
                                        -4096, 4095, 688, 447, -1, -208, 207, -273};
    logic [TimeW-1:0] dir_ms [18] = '{32'd0, 32'd100, 32'd699, 32'd700, 32'd800, 32'd900,
                                      32'd1033, 32'd1232, 32'd1233, 32'd1300,
                                      32'hFFFF_FFFF, 32'd0, 32'd199, 32'd500,
                                      32'h8000_0000, 32'h8000_02BB, 32'h8000_02BC,
                                      32'hFFFF_FF00};
    foreach (dir_roll[i]) send_sample(RollW'(dir_roll[i]), dir_ms[i]);
    send_sample('0, 32'h0000_0100);
  endtask

  task automatic test_random_reset_thresholds();
    drive_walk(150);
  endtask

  task automatic test_random_ordered_thresholds();
    repeat (3) begin
      wait_drain();
      write_ordered_thresholds();
      drive_walk(80);
    end
  endtask

  // all zero, all ones, all at range top, and the two unused indexes
  task automatic test_threshold_extremes();
    wait_drain();
    write_all_thresholds('0);
    send_sample('0, walk_ms);
    drive_walk(12);
    wait_drain();
    write_all_thresholds('1);
    send_sample(RollW'(-4096), walk_ms);
    send_sample(RollW'(4095), walk_ms + 1);
    drive_walk(12);
    wait_drain();
    write_all_thresholds(ThrW'(ROLL_SPAN));
    write_threshold(CFG_SPARE_LO, ThrW'($urandom));
    write_threshold(CFG_SPARE_HI, ThrW'($urandom));
    drive_walk(15);
  endtask

  // thresholds with no ordering at all
  task automatic test_random_unordered_thresholds();
    repeat (2) begin
      wait_drain();
      write_threshold(CFG_WARN_ENTER, ThrW'($urandom));
      write_threshold(CFG_WARN_EXIT, ThrW'($urandom));
      write_threshold(CFG_DANGER_ENTER, ThrW'($urandom));
      write_threshold(CFG_DANGER_EXIT, ThrW'($urandom));
      write_threshold(CFG_ROLLOVER_ENTER, ThrW'($urandom));
      write_threshold(CFG_ROLLOVER_EXIT, ThrW'($urandom));
      drive_walk(60);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block fills
  // up and stalls the sample channel; then the sender waits for a full drain
  task automatic test_backpressure();
    wait_drain();
    write_ordered_thresholds();
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    drive_walk(40);
    wait_drain();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    drive_walk(20);
  endtask

  // closing stretch at full rate with no idling on either side
  task automatic test_full_rate();
    wait_drain();
    write_ordered_thresholds();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    drive_walk(150);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready bursts, plus a long hold when a test asks for it
  // ---------------------------------------------------------------------------
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len != 0) begin
        result_ch.ready = 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      result_ch.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [PwmW-1:0] want,
                             input logic [PwmW-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    lamp_drive_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (owed_drive_q.size() == 0) begin
        $display("%0t result with nothing expected: expected none actual level %0d",
                 $time, result_ch.tilt_level);
        error_count++;
      end else begin
        want = owed_drive_q.pop_front();
        check_field("tilt_level", PwmW'(want.level), PwmW'(result_ch.tilt_level));
        check_field("green_lamp", PwmW'(want.green), PwmW'(result_ch.green_lamp));
        check_field("yellow_lamp", PwmW'(want.yellow), PwmW'(result_ch.yellow_lamp));
        check_field("red_lamp", PwmW'(want.red), PwmW'(result_ch.red_lamp));
        check_field("buzzer_on", PwmW'(want.buzzer), PwmW'(result_ch.buzzer_on));
        check_field("pwm_compare", want.pwm, result_ch.pwm_compare);
      end
    end
  end

  // watchdog: a run with no request moving for too long is a hang
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout, %0d results still expected", $time, owed_drive_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.roll   = '0;
    sample_ch.now_ms = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_WARN_ENTER;
    cfg_ch.data      = '0;
    quiet_cycles     = 0;
    error_count      = 0;
    tx_gaps          = 1'b1;
    rx_gaps          = 1'b1;
    rx_hold_len      = 0;
    walk_roll        = 0;
    walk_ms          = '0;

    // model state after reset
    thr_warn_enter   = WarnEnterRst;
    thr_warn_exit    = WarnExitRst;
    thr_danger_enter = DangerEnterRst;
    thr_danger_exit  = DangerExitRst;
    thr_roll_enter   = RolloverEnterRst;
    thr_roll_exit    = RolloverExitRst;
    alarm_level      = LVL_STABLE;
    toggle_ms        = '0;
    buzz_state       = 1'b0;
    red_state        = 1'b0;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_reset_thresholds();
    test_random_ordered_thresholds();
    test_threshold_extremes();
    test_random_unordered_thresholds();
    test_backpressure();
    test_full_rate();

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tahc_pkg.sv
sv/tahc_in_if.sv
sv/tahc_out_if.sv
sv/tahc_cfg_if.sv
sv/tilt_alarm_hysteresis_controller_core.sv
dv/testbench.sv
